FILE: design/fpm_pkg.sv
package fpm_pkg;

  localparam int NUM_W = 64;
  localparam int DEN_W = 33;
  localparam int Q_W   = 32;
  localparam int TERMS = 6;
  localparam int ADDR_W = 4;

  localparam int T_XS = 0;
  localparam int T_YS = 1;
  localparam int T_XO = 2;
  localparam int T_YO = 3;
  localparam int T_DS = 4;
  localparam int T_DO = 5;

  localparam logic [1:0] REG_INVERT_Y     = 2'd0;
  localparam logic [1:0] REG_INVERT_Z     = 2'd1;
  localparam logic [1:0] REG_HALF_Z_RANGE = 2'd2;

  typedef struct packed {
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
    logic signed [31:0] bottom_edge;
    logic signed [31:0] top_edge;
    logic signed [31:0] near_plane;
    logic signed [31:0] far_plane;
    logic               far_infinite;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_offset;
    logic signed [31:0] depth_scale;
    logic signed [31:0] depth_offset;
    logic               error;
  } out_item_t;

  typedef struct packed {
    logic invert_y;
    logic invert_z;
    logic half_z_range;
  } cfg_t;

  typedef struct packed {
    logic [TERMS-1:0][NUM_W-1:0] num;
    logic [TERMS-1:0][DEN_W-1:0] den;
    logic [TERMS-1:0]            neg;
    logic                        err;
  } job_t;

endpackage

FILE: design/fpm_front.sv
module fpm_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  fpm_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpm_pkg::in_item_t in_item,
  output logic              job_valid,
  input  logic              job_ready,
  output fpm_pkg::job_t     job
);

  function automatic logic [32:0] mag(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    return a[32:0];
  endfunction

  logic signed [33:0] l, r, b, t, n, f;
  logic signed [33:0] dx, dy, dz, sx, sy, n2, snum, off;
  logic [31:0] nm, fm;
  logic [63:0] pm;
  fpm_pkg::job_t j;
  logic en;

  assign en = !job_valid || job_ready;
  assign in_ready = en;

  always_comb begin
    l = 34'(in_item.left_edge);
    r = 34'(in_item.right_edge);
    b = 34'(in_item.bottom_edge);
    t = 34'(in_item.top_edge);
    n = 34'(in_item.near_plane);
    f = 34'(in_item.far_plane);
    dx = r - l;
    dy = t - b;
    dz = cfg.invert_z ? f - n : n - f;
    sx = r + l;
    sy = t + b;
    n2 = n + n;
    snum = cfg.half_z_range ? (cfg.invert_z ? n : f) : n + f;
    off = cfg.half_z_range ? n : n2;
    nm = 32'(mag(n));
    fm = 32'(mag(f));
    pm = 64'(nm) * 64'(fm);
    if (!cfg.half_z_range) pm = pm << 1;

    j.err = (dx == 0) || (dy == 0) || (!in_item.far_infinite && dz == 0);
    j.num[fpm_pkg::T_XS] = fpm_pkg::NUM_W'(mag(n2)) << FRAC_BITS;
    j.num[fpm_pkg::T_YS] = fpm_pkg::NUM_W'(mag(n2)) << FRAC_BITS;
    j.num[fpm_pkg::T_XO] = fpm_pkg::NUM_W'(mag(sx)) << FRAC_BITS;
    j.num[fpm_pkg::T_YO] = fpm_pkg::NUM_W'(mag(sy)) << FRAC_BITS;
    j.den[fpm_pkg::T_XS] = mag(dx);
    j.den[fpm_pkg::T_YS] = mag(dy);
    j.den[fpm_pkg::T_XO] = mag(dx);
    j.den[fpm_pkg::T_YO] = mag(dy);
    j.neg[fpm_pkg::T_XS] = n[33] ^ dx[33];
    j.neg[fpm_pkg::T_YS] = n[33] ^ dy[33] ^ cfg.invert_y;
    j.neg[fpm_pkg::T_XO] = sx[33] ^ dx[33];
    j.neg[fpm_pkg::T_YO] = sy[33] ^ dy[33] ^ cfg.invert_y;
    if (in_item.far_infinite) begin
      j.num[fpm_pkg::T_DS] = (cfg.invert_z && cfg.half_z_range) ? '0
                             : fpm_pkg::NUM_W'(1) << FRAC_BITS;
      j.neg[fpm_pkg::T_DS] = !cfg.invert_z;
      j.num[fpm_pkg::T_DO] = fpm_pkg::NUM_W'(mag(off));
      j.neg[fpm_pkg::T_DO] = cfg.invert_z ? off[33] : (!off[33] && off != 0);
      j.den[fpm_pkg::T_DS] = fpm_pkg::DEN_W'(1);
      j.den[fpm_pkg::T_DO] = fpm_pkg::DEN_W'(1);
    end else begin
      j.num[fpm_pkg::T_DS] = fpm_pkg::NUM_W'(mag(snum)) << FRAC_BITS;
      j.neg[fpm_pkg::T_DS] = snum[33] ^ dz[33];
      j.num[fpm_pkg::T_DO] = pm;
      j.neg[fpm_pkg::T_DO] = n[33] ^ f[33] ^ dz[33];
      j.den[fpm_pkg::T_DS] = mag(dz);
      j.den[fpm_pkg::T_DO] = mag(dz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (en) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) job <= j;
  end

endmodule

FILE: design/fpm_queue.sv
module fpm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  fpm_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fpm_pkg::job_t pop_job
);

  fpm_pkg::job_t mem [0:1];
  logic wp, rp;
  logic [1:0] cnt;
  logic do_push, do_pop;

  assign push_ready = cnt != 2'd2;
  assign pop_valid = cnt != 2'd0;
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_job;
  end

endmodule

FILE: design/fpm_div.sv
module fpm_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fpm_pkg::NUM_W-1:0]  num,
  input  logic [fpm_pkg::DEN_W-1:0]  den,
  output logic [fpm_pkg::Q_W-1:0]    quo,
  output logic                       ovf
);

  localparam int QW = fpm_pkg::Q_W;
  localparam int DW = fpm_pkg::DEN_W;

  logic [DW-1:0] rem [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic [QW-1:0] lo  [0:QW];
  logic [QW-1:0] qq  [0:QW];
  logic          of  [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      of[0] <= {1'b0, num[2*QW-1:QW]} >= den;
      rem[0] <= ({1'b0, num[2*QW-1:QW]} >= den) ? '0 : {1'b0, num[2*QW-1:QW]};
      lo[0] <= num[QW-1:0];
      qq[0] <= '0;
      dd[0] <= den;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic ge;
    assign trial = {rem[k-1], lo[k-1][QW-k]};
    assign diff = trial - {1'b0, dd[k-1]};
    assign ge = trial >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo[k] <= lo[k-1];
        dd[k] <= dd[k-1];
        of[k] <= of[k-1];
        qq[k] <= qq[k-1] | (QW'(ge) << (QW-k));
      end
    end
  end

  assign quo = qq[QW];
  assign ovf = of[QW];

endmodule

FILE: design/fpm_back.sv
module fpm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  fpm_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output fpm_pkg::out_item_t out_item
);

  localparam int QW = fpm_pkg::Q_W;
  localparam int NT = fpm_pkg::TERMS;

  function automatic logic [31:0] sat(input logic [31:0] q, input logic o, input logic ng);
    logic big;
    big = o || q[31];
    if (ng) return big ? 32'h8000_0000 : 32'(-q);
    return big ? 32'h7fff_ffff : q;
  endfunction

  logic en;
  logic vld [0:QW];
  logic [NT-1:0] neg [0:QW];
  logic err [0:QW];
  logic [NT-1:0][QW-1:0] quo;
  logic [NT-1:0] ovf;
  logic [NT-1:0][31:0] res;

  assign en = !out_valid || out_ready;
  assign job_ready = en;

  for (genvar i = 0; i < NT; i++) begin : g_div
    fpm_div u_div (
      .clk (clk),
      .en  (en),
      .num (job.num[i]),
      .den (job.den[i]),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
    assign res[i] = err[QW] ? 32'd0 : sat(quo[i], ovf[i], neg[QW][i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= job_valid;
      for (int k = 1; k <= QW; k++) vld[k] <= vld[k-1];
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= job.neg;
      err[0] <= job.err;
      for (int k = 1; k <= QW; k++) begin
        neg[k] <= neg[k-1];
        err[k] <= err[k-1];
      end
      out_item.x_scale <= res[fpm_pkg::T_XS];
      out_item.y_scale <= res[fpm_pkg::T_YS];
      out_item.x_offset <= res[fpm_pkg::T_XO];
      out_item.y_offset <= res[fpm_pkg::T_YO];
      out_item.depth_scale <= res[fpm_pkg::T_DS];
      out_item.depth_offset <= res[fpm_pkg::T_DO];
      out_item.error <= err[QW];
    end
  end

endmodule

FILE: design/frustum_projection_matrix.sv
// throughput: one request per cycle while out_ready is high, set by the restoring divider bank
// front stage and 2-entry queue stall apart; divider pipeline and output register stall together
// reset: synchronous active-high rst clears control state and config to zero
module frustum_projection_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpm_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fpm_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fpm_pkg::cfg_t cfg;
  logic wr;
  logic [1:0] idx;
  logic f_valid, f_ready, q_valid, q_ready;
  fpm_pkg::job_t f_job, q_job;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        fpm_pkg::REG_INVERT_Y:     cfg.invert_y <= pwdata[0];
        fpm_pkg::REG_INVERT_Z:     cfg.invert_z <= pwdata[0];
        fpm_pkg::REG_HALF_Z_RANGE: cfg.half_z_range <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fpm_pkg::REG_INVERT_Y:     prdata = {31'd0, cfg.invert_y};
      fpm_pkg::REG_INVERT_Z:     prdata = {31'd0, cfg.invert_z};
      fpm_pkg::REG_HALF_Z_RANGE: prdata = {31'd0, cfg.half_z_range};
      default:                   prdata = 32'd0;
    endcase
  end

  fpm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  fpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  fpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: design/fpm_checker.sv
module fpm_props (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input fpm_pkg::out_item_t out_item,
  input logic               pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error |-> out_item.x_scale == 0 && out_item.y_scale == 0 &&
      out_item.x_offset == 0 && out_item.y_offset == 0 &&
      out_item.depth_scale == 0 && out_item.depth_offset == 0)
    else $error("error result with nonzero terms");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind frustum_projection_matrix fpm_props u_fpm_props (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .pready    (pready)
);

FILE: bench/fpm_checker.sv
`timescale 1ns / 1ps
module fpm_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  fpm_pkg::in_item_t           in_item,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  fpm_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int                          fails,
  output int                          pending
);

  localparam int FRAC = 16;

  fpm_pkg::out_item_t matrix_q[$];
  logic flip_y, flip_z, half_depth;
  int seen;

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] clamp32(longint unsigned m, bit neg);
    if (neg) begin
      if (m >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-m);
    end
    if (m > 64'h7fff_ffff) return 32'h7fff_ffff;
    return 32'(m);
  endfunction

  function automatic logic [31:0] quotient(longint unsigned nmag, bit nneg, longint den,
                                           bit flip);
    return clamp32(nmag / magnitude(den), nneg ^ (den < 0) ^ flip);
  endfunction

  function automatic fpm_pkg::out_item_t project(fpm_pkg::in_item_t it, bit iy, bit iz,
                                                 bit half);
    fpm_pkg::out_item_t o;
    longint l, r, b, t, n, f, dx, dy, dz, off, snum;
    longint unsigned one, pm;
    l = longint'(it.left_edge);
    r = longint'(it.right_edge);
    b = longint'(it.bottom_edge);
    t = longint'(it.top_edge);
    n = longint'(it.near_plane);
    f = longint'(it.far_plane);
    one = 64'd1 << FRAC;
    dx = r - l;
    dy = t - b;
    dz = iz ? f - n : n - f;
    o = '0;
    if (dx == 0 || dy == 0 || (!it.far_infinite && dz == 0)) begin
      o.error = 1'b1;
      return o;
    end
    o.x_scale  = quotient(magnitude(2 * n) * one, n < 0, dx, 1'b0);
    o.y_scale  = quotient(magnitude(2 * n) * one, n < 0, dy, iy);
    o.x_offset = quotient(magnitude(r + l) * one, (r + l) < 0, dx, 1'b0);
    o.y_offset = quotient(magnitude(t + b) * one, (t + b) < 0, dy, iy);
    if (it.far_infinite) begin
      off = half ? n : 2 * n;
      if (iz) o.depth_scale = half ? 32'd0 : clamp32(one, 1'b0);
      else o.depth_scale = clamp32(one, 1'b1);
      o.depth_offset = clamp32(magnitude(off), iz ? (off < 0) : (off > 0));
    end else begin
      snum = half ? (iz ? n : f) : n + f;
      pm = magnitude(n) * magnitude(f);
      if (!half) pm = pm * 2;
      o.depth_scale  = quotient(magnitude(snum) * one, snum < 0, dz, 1'b0);
      o.depth_offset = quotient(pm, (n < 0) != (f < 0), dz, 1'b0);
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d field %s: got %h, expected %h", seen, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    seen = 0;
  end

  always @(posedge clk) begin
    fpm_pkg::out_item_t want;
    if (rst) begin
      matrix_q.delete();
      flip_y = 1'b0;
      flip_z = 1'b0;
      half_depth = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fpm_pkg::REG_INVERT_Y:     flip_y = pwdata[0];
          fpm_pkg::REG_INVERT_Z:     flip_z = pwdata[0];
          fpm_pkg::REG_HALF_Z_RANGE: half_depth = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        matrix_q.push_back(project(in_item, flip_y, flip_z, half_depth));
      if (out_valid && out_ready) begin
        if (matrix_q.size() == 0) begin
          report("unexpected x_scale", out_item.x_scale, 32'hx);
        end else begin
          want = matrix_q.pop_front();
          if (out_item.x_scale !== want.x_scale)
            report("x_scale", out_item.x_scale, want.x_scale);
          if (out_item.y_scale !== want.y_scale)
            report("y_scale", out_item.y_scale, want.y_scale);
          if (out_item.x_offset !== want.x_offset)
            report("x_offset", out_item.x_offset, want.x_offset);
          if (out_item.y_offset !== want.y_offset)
            report("y_offset", out_item.y_offset, want.y_offset);
          if (out_item.depth_scale !== want.depth_scale)
            report("depth_scale", out_item.depth_scale, want.depth_scale);
          if (out_item.depth_offset !== want.depth_offset)
            report("depth_offset", out_item.depth_offset, want.depth_offset);
          if (out_item.error !== want.error)
            report("error", 32'(out_item.error), 32'(want.error));
        end
        seen++;
      end
    end
    pending = matrix_q.size();
  end
endmodule

FILE: bench/tb_frustum_projection_matrix.sv
`timescale 1ns / 1ps
module tb_frustum_projection_matrix;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  fpm_pkg::in_item_t in_item;
  fpm_pkg::out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [fpm_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fails, pending;
  bit lazy;

  frustum_projection_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fpm_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(fpm_pkg::in_item_t it);
    if (lazy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'($urandom_range(0, 8)) << 16;
      default: return 32'($urandom_range(0, 200 << 16)) - (32'd100 << 16);
    endcase
  endfunction

  function automatic fpm_pkg::in_item_t random_frustum();
    fpm_pkg::in_item_t it;
    it.left_edge = pick_edge();
    it.right_edge = pick_edge();
    it.bottom_edge = pick_edge();
    it.top_edge = pick_edge();
    it.near_plane = pick_edge();
    it.far_plane = pick_edge();
    it.far_infinite = $urandom_range(0, 3) == 0;
    case ($urandom_range(0, 15))
      0: it.right_edge = it.left_edge;
      1: it.top_edge = it.bottom_edge;
      2: it.far_plane = it.near_plane;
      default: ;
    endcase
    return it;
  endfunction

  function automatic fpm_pkg::in_item_t frustum(logic [31:0] l, logic [31:0] r,
                                                logic [31:0] b, logic [31:0] t,
                                                logic [31:0] n, logic [31:0] f,
                                                logic inf);
    fpm_pkg::in_item_t it;
    it = '{l, r, b, t, n, f, inf};
    return it;
  endfunction

  task automatic directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send(frustum(-32'h10000, 32'h10000, -32'h10000, 32'h10000, 32'h1000, 32'h640000, 1'b0));
    send(frustum(-32'h10000, 32'h10000, -32'h10000, 32'h10000, 32'h1000, 32'h640000, 1'b1));
    send(frustum(mn, mx, mn, mx, mx, mn, 1'b0));
    send(frustum(mx, mn, mx, mn, mn, mx, 1'b0));
    send(frustum(mn, mx, mn, mx, mn, mn, 1'b1));
    send(frustum(mn, mx, mn, mx, mx, mx, 1'b1));
    send(frustum(0, 1, 0, 1, mx, mn, 1'b0));
    send(frustum(0, 1, 0, 1, mn, mx, 1'b0));
    send(frustum(1, 0, 1, 0, mx, 0, 1'b1));
    send(frustum(mx, mx, 0, 1, 32'h10000, 32'h20000, 1'b0));
    send(frustum(0, 1, mn, mn, 32'h10000, 32'h20000, 1'b0));
    send(frustum(0, 1, 0, 1, 32'h10000, 32'h10000, 1'b0));
    send(frustum(0, 1, 0, 1, 32'h10000, 32'h10000, 1'b1));
    send(frustum(0, 0, 0, 0, 0, 0, 1'b1));
    send(frustum(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    send(frustum(-32'h30000, 32'h10000, 32'h20000, -32'h50000, -32'h8000, 32'h90000, 1'b0));
    send(frustum(mn, 0, mn, 0, mx, mx, 1'b0));
    send(frustum(0, mx, 0, mx, 1, 2, 1'b0));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    lazy = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    directed();
    for (int setting = 0; setting < 8; setting++) begin
      in_valid <= 1'b0;
      drain();
      reg_write(fpm_pkg::REG_INVERT_Y, {$urandom} << 1 | setting[0]);
      reg_write(fpm_pkg::REG_INVERT_Z, {$urandom} << 1 | setting[1]);
      reg_write(fpm_pkg::REG_HALF_Z_RANGE, {$urandom} << 1 | setting[2]);
      directed();
      for (int k = 0; k < 75; k++) begin
        if (setting == 7 && k > 30) lazy = 1'b0;
        send(random_frustum());
      end
    end
    in_valid <= 1'b0;
    drain();
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (lazy && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end
endmodule

FILE: files.f
design/fpm_pkg.sv
design/fpm_front.sv
design/fpm_queue.sv
design/fpm_div.sv
design/fpm_back.sv
design/frustum_projection_matrix.sv
design/fpm_checker.sv
bench/fpm_checker.sv
bench/tb_frustum_projection_matrix.sv
